// ----- hw/rtl/packet_jitter_reorder_buffer_assert.svh -----
// Assertion macros used by the checker of the jitter buffer.
`ifndef PACKET_JITTER_REORDER_BUFFER_ASSERT_SVH
`define PACKET_JITTER_REORDER_BUFFER_ASSERT_SVH

// Same-cycle implication, masked while reset is low.
`define PJRB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("jitter buffer: same-cycle check failed");

// Next-cycle implication, masked while reset is low.
`define PJRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("jitter buffer: next-cycle check failed");

`endif

// ----- hw/rtl/pjrb_pkg.sv -----
package pjrb_pkg;

    // Table size default
    localparam int CAPACITY_DEF = 64;

    // Field widths
    localparam int SEQ_W   = 16;
    localparam int LEN_W   = 11;
    localparam int REF_W   = 16;
    localparam int PLEN_W  = 16;
    localparam int DLEN_W  = 12;
    localparam int MAGIC_W = 16;
    localparam int BYTE_W  = 8;

    // Stream widths
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;
    localparam int M_PAD_W   = M_TDATA_W - SEQ_W - LEN_W - REF_W;

    // Header size in bytes
    localparam logic [DLEN_W-1:0] HDR_BYTES = 12'd12;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PTYPE   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXLEN  = 8'd3;

    // Register reset values
    localparam logic [MAGIC_W-1:0] MAGIC_RST   = 16'h5353;
    localparam logic [BYTE_W-1:0]  VERSION_RST = 8'd1;
    localparam logic [BYTE_W-1:0]  PTYPE_RST   = 8'd0;
    localparam logic [LEN_W-1:0]   MAXLEN_RST  = 11'd1275;

    // Request kinds carried on tuser
    localparam logic REQ_PKT  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // One table slot as held in the memory
    typedef struct packed {
        logic             vld;
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;
        logic [REF_W-1:0] pref;
    } t_slot;

    // Header fields checked against the configuration
    typedef struct packed {
        logic [MAGIC_W-1:0] magic;
        logic [BYTE_W-1:0]  version;
        logic [BYTE_W-1:0]  ptype;
        logic [PLEN_W-1:0]  plen;
        logic [DLEN_W-1:0]  dlen;
    } t_hdr;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_WRITE,
        ST_OUT
    } t_state;

    // True when a lies behind b in wrap-safe order
    function automatic logic seq_behind(input logic [SEQ_W-1:0] a,
                                        input logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] d;
        d = a - b;
        return d[SEQ_W-1];
    endfunction

endpackage

// ----- hw/rtl/packet_jitter_reorder_buffer.sv -----
// Channel   Direction  Handshake               Payload
// s stream  in         i_s_tvalid/o_s_tready   tuser kind, tdata packet header
// m stream  out        o_m_tvalid/i_m_tready   tuser flags, tdata playout result
// cfg       in         i_cfg_valid/o_cfg_ready register index and write data
//
// Packet: accepted in idle, then CAPACITY slot reads on the registered port and a
// write of the free slot, none for a duplicate. A rejected, late or table-full packet
// is taken in idle with no sweep. Tick: CAPACITY slot reads plus any wait for the
// output register; no sweep before the first packet. No new item is taken during a
// sweep. The rate is set by the slot memory's single read port, one slot per cycle.
// After reset a clearing pass writes every slot, taking no input; cfg always taken.
module packet_jitter_reorder_buffer #(
    parameter int CAPACITY = pjrb_pkg::CAPACITY_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // tdata: hdr_magic[15:0], hdr_version[23:16], hdr_payload_type[31:24],
    // pkt_seq[47:32], pkt_payload_len[63:48], datagram_len[75:64],
    // pkt_payload_ref[91:76], zero [95:92]
    input  logic [pjrb_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // tuser: req_type[0]
    input  logic                             i_s_tuser,
    // Output stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // tdata: played_seq[15:0], out_payload_len[26:16], out_payload_ref[42:27],
    // zero [47:43]
    output logic [pjrb_pkg::M_TDATA_W-1:0]   o_m_tdata,
    // tuser: found[0], started[1]
    output logic [pjrb_pkg::M_TUSER_W-1:0]   o_m_tuser,
    // Configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pjrb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pjrb_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int AW     = $clog2(CAPACITY);
    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int SLOT_W = $bits(pjrb_pkg::t_slot);
    localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

    pjrb_pkg::t_state r_state, n_state;

    // Sweep control
    logic [AW-1:0] r_idx;
    logic          r_issue;
    logic          r_chk_vld;
    logic          r_chk_last;
    logic [AW-1:0] r_chk_addr;

    // Item held during its sweep
    logic                       r_kind;
    logic [pjrb_pkg::SEQ_W-1:0] r_pkt_seq;
    logic [pjrb_pkg::LEN_W-1:0] r_pkt_len;
    logic [pjrb_pkg::REF_W-1:0] r_pkt_ref;
    logic                       r_dup;
    logic                       r_free_vld;
    logic [AW-1:0]              r_free_addr;
    logic                       r_found;
    logic [pjrb_pkg::LEN_W-1:0] r_hit_len;
    logic [pjrb_pkg::REF_W-1:0] r_hit_ref;

    // Buffer state
    logic [CW-1:0]              r_count;
    logic [pjrb_pkg::SEQ_W-1:0] r_next_seq;
    logic                       r_have;

    // Output register
    logic                           r_out_vld;
    logic [pjrb_pkg::M_TDATA_W-1:0] r_out_data;
    logic [pjrb_pkg::M_TUSER_W-1:0] r_out_user;

    // Memory ports
    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    logic [SLOT_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [SLOT_W-1:0] ram_rd_data;

    pjrb_pkg::t_hdr  in_hdr;
    pjrb_pkg::t_slot rd_slot;
    pjrb_pkg::t_slot cleared_slot;
    pjrb_pkg::t_slot new_slot;
    logic [pjrb_pkg::SEQ_W-1:0] in_seq;
    logic [pjrb_pkg::REF_W-1:0] in_ref;

    logic s_ready;
    logic in_acc;
    logic in_tick;
    logic pkt_ok;
    logic pkt_behind;
    logic pkt_store;
    logic tbl_full;
    logic tick_hit;
    logic tick_clr;
    logic pkt_dup;
    logic pkt_free;
    logic sweep_dup;
    logic sweep_free;
    logic sweep_done;
    logic out_load;

    // Unpack the input transaction
    assign in_hdr.magic   = i_s_tdata[15:0];
    assign in_hdr.version = i_s_tdata[23:16];
    assign in_hdr.ptype   = i_s_tdata[31:24];
    assign in_seq         = i_s_tdata[47:32];
    assign in_hdr.plen    = i_s_tdata[63:48];
    assign in_hdr.dlen    = i_s_tdata[75:64];
    assign in_ref         = i_s_tdata[91:76];

    pjrb_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .i_hdr      (in_hdr),
        .o_pkt_ok   (pkt_ok)
    );

    pjrb_ram #(
        .W     (SLOT_W),
        .DEPTH (CAPACITY)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (ram_rd_data)
    );

    // Decide on the accepted transaction
    assign in_acc     = i_s_tvalid && s_ready;
    assign in_tick    = (i_s_tuser == pjrb_pkg::REQ_TICK);
    assign tbl_full   = (r_count == FULL_CNT);
    assign pkt_behind = r_have && pjrb_pkg::seq_behind(in_seq, r_next_seq);
    assign pkt_store  = pkt_ok && !pkt_behind && !tbl_full;

    // Examine the slot returned by the memory
    always_comb begin
        rd_slot    = pjrb_pkg::t_slot'(ram_rd_data);
        tick_hit   = rd_slot.vld && (rd_slot.seq == r_next_seq);
        tick_clr   = tick_hit
                  || (rd_slot.vld && pjrb_pkg::seq_behind(rd_slot.seq, r_next_seq));
        pkt_dup    = rd_slot.vld && (rd_slot.seq == r_pkt_seq);
        pkt_free   = !rd_slot.vld;
        sweep_dup  = r_dup || (r_chk_vld && pkt_dup);
        sweep_free = r_free_vld || (r_chk_vld && pkt_free);
        sweep_done = r_chk_vld && r_chk_last;

        cleared_slot     = rd_slot;
        cleared_slot.vld = 1'b0;

        new_slot.vld  = 1'b1;
        new_slot.seq  = r_pkt_seq;
        new_slot.len  = r_pkt_len;
        new_slot.pref = r_pkt_ref;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pjrb_pkg::ST_CLEAR: begin
                if (r_idx == LAST_IDX) begin
                    n_state = pjrb_pkg::ST_IDLE;
                end
            end
            pjrb_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (in_tick) begin
                        n_state = r_have ? pjrb_pkg::ST_SWEEP : pjrb_pkg::ST_OUT;
                    end else if (pkt_store) begin
                        n_state = pjrb_pkg::ST_SWEEP;
                    end
                end
            end
            pjrb_pkg::ST_SWEEP: begin
                if (sweep_done) begin
                    if (r_kind == pjrb_pkg::REQ_TICK) begin
                        n_state = pjrb_pkg::ST_OUT;
                    end else if (sweep_free && !sweep_dup) begin
                        n_state = pjrb_pkg::ST_WRITE;
                    end else begin
                        n_state = pjrb_pkg::ST_IDLE;
                    end
                end
            end
            pjrb_pkg::ST_WRITE: begin
                n_state = pjrb_pkg::ST_IDLE;
            end
            pjrb_pkg::ST_OUT: begin
                if (out_load) begin
                    n_state = pjrb_pkg::ST_IDLE;
                end
            end
            default: n_state = pjrb_pkg::ST_IDLE;
        endcase
    end

    // State outputs: memory control, ready and output load
    always_comb begin
        s_ready     = 1'b0;
        ram_rd_en   = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_idx;
        ram_wr_data = '0;
        out_load    = 1'b0;
        unique case (r_state)
            pjrb_pkg::ST_CLEAR: begin
                ram_wr_en = 1'b1;
            end
            pjrb_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            pjrb_pkg::ST_SWEEP: begin
                ram_rd_en   = r_issue;
                ram_wr_en   = r_chk_vld && (r_kind == pjrb_pkg::REQ_TICK) && tick_clr;
                ram_wr_addr = r_chk_addr;
                ram_wr_data = SLOT_W'(cleared_slot);
            end
            pjrb_pkg::ST_WRITE: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_free_addr;
                ram_wr_data = SLOT_W'(new_slot);
            end
            pjrb_pkg::ST_OUT: begin
                out_load = !r_out_vld || i_m_tready;
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= pjrb_pkg::ST_CLEAR;
            r_idx      <= '0;
            r_issue    <= 1'b0;
            r_chk_vld  <= 1'b0;
            r_chk_last <= 1'b0;
            r_kind     <= pjrb_pkg::REQ_PKT;
            r_dup      <= 1'b0;
            r_free_vld <= 1'b0;
            r_found    <= 1'b0;
            r_count    <= '0;
            r_next_seq <= '0;
            r_have     <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_chk_vld  <= ram_rd_en;
            r_chk_last <= (r_idx == LAST_IDX);

            // Walk the clearing pass, leave the index at zero for the first sweep
            if (r_state == pjrb_pkg::ST_CLEAR) begin
                r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
            end

            // Issue one slot read a cycle
            if (ram_rd_en) begin
                if (r_idx == LAST_IDX) begin
                    r_issue <= 1'b0;
                    r_idx   <= '0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end

            // Take the transaction and start its sweep
            if (in_acc) begin
                r_kind <= i_s_tuser;
                if (in_tick) begin
                    r_found <= 1'b0;
                    r_issue <= r_have;
                end else begin
                    if (pkt_ok && !r_have) begin
                        r_have     <= 1'b1;
                        r_next_seq <= in_seq;
                    end
                    r_dup      <= 1'b0;
                    r_free_vld <= 1'b0;
                    r_issue    <= pkt_store;
                end
            end

            // Fold in each returned slot
            if (r_chk_vld) begin
                if (r_kind == pjrb_pkg::REQ_TICK) begin
                    if (tick_hit) begin
                        r_found <= 1'b1;
                    end
                    if (tick_clr) begin
                        r_count <= r_count - 1'b1;
                    end
                end else begin
                    if (pkt_dup) begin
                        r_dup <= 1'b1;
                    end
                    if (pkt_free) begin
                        r_free_vld <= 1'b1;
                    end
                end
            end

            // Count the stored packet
            if (r_state == pjrb_pkg::ST_WRITE) begin
                r_count <= r_count + 1'b1;
            end

            // Load the next result and advance, else drop the result once taken
            if (out_load) begin
                r_out_vld <= 1'b1;
                if (r_have) begin
                    r_next_seq <= r_next_seq + 1'b1;
                end
            end else if (r_out_vld && i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_chk_addr <= r_idx;
        if (in_acc) begin
            r_pkt_seq <= in_seq;
            r_pkt_len <= in_hdr.plen[pjrb_pkg::LEN_W-1:0];
            r_pkt_ref <= in_ref;
            if (in_tick) begin
                r_hit_len <= '0;
                r_hit_ref <= '0;
            end
        end
        if (r_chk_vld) begin
            if ((r_kind == pjrb_pkg::REQ_TICK) && tick_hit) begin
                r_hit_len <= rd_slot.len;
                r_hit_ref <= rd_slot.pref;
            end
            if ((r_kind == pjrb_pkg::REQ_PKT) && pkt_free && !r_free_vld) begin
                r_free_addr <= r_chk_addr;
            end
        end
        if (out_load) begin
            r_out_data <= {{pjrb_pkg::M_PAD_W{1'b0}}, r_hit_ref, r_hit_len, r_next_seq};
            r_out_user <= {r_have, r_found};
        end
    end

    assign o_s_tready  = s_ready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_vld;
    assign o_m_tdata   = r_out_data;
    assign o_m_tuser   = r_out_user;

endmodule

// ----- hw/rtl/pjrb_ram.sv -----
module pjrb_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [W-1:0]             i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [W-1:0]             o_rd_data
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/pjrb_cfg.sv -----
module pjrb_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_en,
    input  logic [pjrb_pkg::CFG_IDX_W-1:0]   i_wr_index,
    input  logic [pjrb_pkg::CFG_DATA_W-1:0]  i_wr_data,
    input  pjrb_pkg::t_hdr                   i_hdr,
    output logic                             o_pkt_ok
);

    localparam int SUM_W = pjrb_pkg::PLEN_W + 1;

    logic [pjrb_pkg::MAGIC_W-1:0] r_magic;
    logic [pjrb_pkg::BYTE_W-1:0]  r_version;
    logic [pjrb_pkg::BYTE_W-1:0]  r_ptype;
    logic [pjrb_pkg::LEN_W-1:0]   r_maxlen;

    logic [SUM_W-1:0] need_len;
    logic [SUM_W-1:0] dlen_ext;
    logic [SUM_W-1:0] maxlen_ext;
    logic [SUM_W-1:0] plen_ext;

    // Register writes; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic   <= pjrb_pkg::MAGIC_RST;
            r_version <= pjrb_pkg::VERSION_RST;
            r_ptype   <= pjrb_pkg::PTYPE_RST;
            r_maxlen  <= pjrb_pkg::MAXLEN_RST;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                pjrb_pkg::CFG_MAGIC:   r_magic   <= i_wr_data[pjrb_pkg::MAGIC_W-1:0];
                pjrb_pkg::CFG_VERSION: r_version <= i_wr_data[pjrb_pkg::BYTE_W-1:0];
                pjrb_pkg::CFG_PTYPE:   r_ptype   <= i_wr_data[pjrb_pkg::BYTE_W-1:0];
                pjrb_pkg::CFG_MAXLEN:  r_maxlen  <= i_wr_data[pjrb_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Header and length checks
    assign plen_ext   = SUM_W'(i_hdr.plen);
    assign need_len   = plen_ext + SUM_W'(pjrb_pkg::HDR_BYTES);
    assign dlen_ext   = SUM_W'(i_hdr.dlen);
    assign maxlen_ext = SUM_W'(r_maxlen);

    assign o_pkt_ok = (i_hdr.dlen >= pjrb_pkg::HDR_BYTES)
                   && (i_hdr.magic == r_magic)
                   && (i_hdr.version == r_version)
                   && (i_hdr.ptype == r_ptype)
                   && (plen_ext <= maxlen_ext)
                   && (need_len <= dlen_ext);

endmodule

// ----- hw/rtl/packet_jitter_reorder_buffer_checker.sv -----
`include "packet_jitter_reorder_buffer_assert.svh"

module packet_jitter_reorder_buffer_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [pjrb_pkg::M_TDATA_W-1:0] o_m_tdata,
    input logic [pjrb_pkg::M_TUSER_W-1:0] o_m_tuser
);

    // Hold a stalled result
    `PJRB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))

    // A miss carries no length and no descriptor
    `PJRB_ASSERT_IMPL(a_miss_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser[0], o_m_tdata[42:16] == 27'd0)

    // A hit only once started
    `PJRB_ASSERT_IMPL(a_hit_started, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0], o_m_tuser[1])

    // Before the first packet the expected number stays at its reset value
    `PJRB_ASSERT_IMPL(a_idle_seq, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser[1], o_m_tdata[15:0] == 16'd0)

endmodule

bind packet_jitter_reorder_buffer packet_jitter_reorder_buffer_checker u_checker (.*);
